>>> rtl/mtp_pkg.sv
// mtp_pkg: shared types and constants of the markov top-k symbol predictor
// depends on nothing; used by the rank unit, the top level and the bench of the predictor
`default_nettype none

package mtp_pkg;

  localparam int SYM_W   = 6;   // width of a symbol field and of a rank
  localparam int TOPK_W  = 6;   // width of the top_k register
  localparam int REPORT_W = 16; // width of the reported count

  localparam logic [TOPK_W-1:0] TOPK_RESET = 6'd4;

  localparam logic CMD_TRAIN = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             command;
    logic [SYM_W-1:0] symbol;
    logic [SYM_W-1:0] next_symbol;
  } mtp_in_t;

  typedef struct packed {
    logic                hit;
    logic [SYM_W-1:0]    rank;
    logic [REPORT_W-1:0] next_count;
  } mtp_out_t;

  // sequencer to rank unit
  typedef struct packed {
    logic load;  // read data is the target count, clear the rank
    logic step;  // read data is one row entry, compare and count
  } mtp_rank_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/mtp_count_ram.sv
// mtp_count_ram: transition count memory, one write and one registered read port
// depends on nothing
`default_nettype none

module mtp_count_ram #(
  parameter int DEPTH  = 2704,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/mtp_rank_unit.sv
// mtp_rank_unit: shared compare unit, counts row entries that outrank the target
// depends on mtp_pkg
`default_nettype none

module mtp_rank_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire mtp_pkg::mtp_rank_ctrl_t      ctrl,
  input  wire logic [COUNT_WIDTH-1:0]       data,
  input  wire logic [mtp_pkg::SYM_W-1:0]    col,
  input  wire logic [mtp_pkg::SYM_W-1:0]    nxt,
  output logic      [COUNT_WIDTH-1:0]       target,
  output logic      [mtp_pkg::SYM_W-1:0]    rank
);

  logic [COUNT_WIDTH-1:0]    target_r;
  logic [mtp_pkg::SYM_W-1:0] rank_r;
  logic                      beats;

  // ties go to the higher symbol index
  assign beats = (data > target_r) || ((data == target_r) && (col > nxt));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      target_r <= data;
      rank_r   <= '0;
    end else if (ctrl.step && beats) begin
      rank_r <= rank_r + 1'b1;
    end
  end

  assign target = target_r;
  assign rank   = rank_r;

endmodule

`default_nettype wire

>>> rtl/markov_topk_symbol_predictor_unit.sv
// markov_topk_symbol_predictor_unit: top level, sequencer, registers and output stage
// depends on mtp_pkg, mtp_count_ram and mtp_rank_unit
`default_nettype none

// First-order markov successor predictor. A train beat (command 0) bumps the
// saturating count from the previously trained symbol to this one and makes it
// the new predecessor; the result carries the updated count. A query beat
// (command 1) ranks the row of `symbol` by count, ties going to the higher
// index, and returns the rank of `next_symbol`, its count and hit = rank < top_k.
// Exactly one result beat per input beat. The counts live in a single-port-read
// memory of ALPHABET_SIZE^2 entries, and a query walks its row one entry per
// cycle through one shared compare unit. A query passes through the target
// read, the load and the row scan before its result; a train beat through a
// read and a write; out-of-range or first train beats go straight to the
// result. A stalled result holds the block. The block takes one beat at a time.
// After reset a clearing pass zeroes all ALPHABET_SIZE^2 entries of the memory,
// one entry per cycle, during which in_stall stays high; cfg writes are taken
// at any time.
module markov_topk_symbol_predictor_unit #(
  parameter int ALPHABET_SIZE = 52,
  parameter int COUNT_WIDTH   = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire mtp_pkg::mtp_in_t            in_data,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output mtp_pkg::mtp_out_t                out_data,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [mtp_pkg::TOPK_W-1:0]  cfg_wdata
);

  localparam int DEPTH  = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SYM_W  = mtp_pkg::SYM_W;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] ROW_LEN   = ADDR_W'(ALPHABET_SIZE);
  localparam logic [SYM_W-1:0]  LAST_SYM  = SYM_W'(ALPHABET_SIZE - 1);
  localparam logic [SYM_W:0]    SYM_LIMIT = (SYM_W + 1)'(ALPHABET_SIZE);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_TRAIN_RD = 8'b0000_0100,
    S_TRAIN_WR = 8'b0000_1000,
    S_Q_TGT    = 8'b0001_0000,
    S_Q_LOAD   = 8'b0010_0000,
    S_Q_SCAN   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  // saturate a stored count into the 16-bit result field
  function automatic logic [mtp_pkg::REPORT_W-1:0] report_count(
    input logic [COUNT_WIDTH-1:0] c
  );
    logic [COUNT_WIDTH+15:0] ext;
    ext = {16'd0, c};
    if (ext > (COUNT_WIDTH + 16)'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return ext[15:0];
  endfunction

  state_t                       state_r, state_nxt;
  logic [ADDR_W-1:0]            clr_addr_r;
  logic [mtp_pkg::TOPK_W-1:0]   top_k_r;
  logic [SYM_W-1:0]             prev_sym_r;
  logic                         prev_valid_r;
  logic [ADDR_W-1:0]            addr_r;      // train cell or query target cell
  logic [ADDR_W-1:0]            base_r;      // first cell of the queried row
  logic [SYM_W-1:0]             nxt_r;
  logic [SYM_W-1:0]             idx_r;       // row entry now on the read data
  mtp_pkg::mtp_out_t            res_r;
  logic                         res_rank_r;  // result comes from the rank unit
  mtp_pkg::mtp_out_t            out_r;
  logic                         out_valid_r;

  logic                         in_acc;
  logic                         sym_ok;
  logic                         nxt_ok;
  logic                         is_query;
  logic                         out_free;
  logic                         scan_last;
  logic [ADDR_W-1:0]            train_addr;
  logic [ADDR_W-1:0]            row_base;

  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [COUNT_WIDTH-1:0]       mem_wdata;
  logic [ADDR_W-1:0]            mem_raddr;
  logic [COUNT_WIDTH-1:0]       mem_rdata;
  logic [COUNT_WIDTH-1:0]       inc_count;

  mtp_pkg::mtp_rank_ctrl_t      rank_ctrl;
  logic [COUNT_WIDTH-1:0]       rank_target;
  logic [SYM_W-1:0]             rank_val;
  mtp_pkg::mtp_out_t            fin_res;

  // handshake
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // decode of the incoming beat
  assign is_query   = (in_data.command == mtp_pkg::CMD_QUERY);
  assign sym_ok     = ({1'b0, in_data.symbol} < SYM_LIMIT);
  assign nxt_ok     = ({1'b0, in_data.next_symbol} < SYM_LIMIT);
  assign row_base   = ADDR_W'(in_data.symbol) * ROW_LEN;
  assign train_addr = ADDR_W'(prev_sym_r) * ROW_LEN + ADDR_W'(in_data.symbol);
  assign scan_last  = (idx_r == LAST_SYM);

  // saturating increment of the count just read
  assign inc_count = (mem_rdata == {COUNT_WIDTH{1'b1}}) ? mem_rdata : mem_rdata + 1'b1;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (!is_query) begin
            state_nxt = (sym_ok && prev_valid_r) ? S_TRAIN_RD : S_DONE;
          end else begin
            state_nxt = (sym_ok && nxt_ok) ? S_Q_TGT : S_DONE;
          end
        end
      end
      S_TRAIN_RD: state_nxt = S_TRAIN_WR;
      S_TRAIN_WR: state_nxt = S_DONE;
      S_Q_TGT:    state_nxt = S_Q_LOAD;
      S_Q_LOAD:   state_nxt = S_Q_SCAN;
      S_Q_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = inc_count;
    mem_raddr = addr_r;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      S_TRAIN_WR: mem_we = 1'b1;
      // target arrives in load; row entry 0 is fetched meanwhile
      S_Q_LOAD:   mem_raddr = base_r;
      S_Q_SCAN:   mem_raddr = scan_last ? base_r : base_r + ADDR_W'(idx_r) + 1'b1;
      default:    mem_raddr = addr_r;
    endcase
  end

  always_comb begin
    rank_ctrl.load = (state_r == S_Q_LOAD);
    rank_ctrl.step = (state_r == S_Q_SCAN);
  end

  // finished query result from the rank unit
  always_comb begin
    fin_res            = res_r;
    if (res_rank_r) begin
      fin_res.rank       = rank_val;
      fin_res.hit        = (rank_val < top_k_r);
      fin_res.next_count = report_count(rank_target);
    end
  end

  mtp_count_ram #(
    .DEPTH  (DEPTH),
    .WIDTH  (COUNT_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mtp_rank_unit #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_rank (
    .clk    (clk),
    .ctrl   (rank_ctrl),
    .data   (mem_rdata),
    .col    (idx_r),
    .nxt    (nxt_r),
    .target (rank_target),
    .rank   (rank_val)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      top_k_r      <= mtp_pkg::TOPK_RESET;
      prev_sym_r   <= '0;
      prev_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cfg_we) begin
        top_k_r <= cfg_wdata;
      end
      // predecessor moves on with every in-range train beat
      if (in_acc && !is_query && sym_ok) begin
        prev_sym_r   <= in_data.symbol;
        prev_valid_r <= 1'b1;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      nxt_r      <= in_data.next_symbol;
      base_r     <= row_base;
      addr_r     <= is_query ? row_base + ADDR_W'(in_data.next_symbol) : train_addr;
      res_rank_r <= is_query && sym_ok && nxt_ok;
      res_r.hit        <= 1'b0;
      res_r.rank       <= is_query ? LAST_SYM : '0;
      res_r.next_count <= '0;
    end
    if (state_r == S_TRAIN_WR) begin
      res_r.next_count <= report_count(inc_count);
    end
    if (state_r == S_Q_LOAD) begin
      idx_r <= '0;
    end else if (state_r == S_Q_SCAN) begin
      idx_r <= idx_r + 1'b1;
    end
    if (state_r == S_DONE && out_free) begin
      out_r <= fin_res;
    end
  end

  // memory is written only by the clearing pass or a train update
  a_mem_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_TRAIN_WR))
    else $error("count memory written outside clear or train update");

  // a reported rank never leaves the alphabet
  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.rank <= LAST_SYM))
    else $error("rank beyond alphabet");

  // a hit always comes with a rank inside top_k
  a_hit_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.hit) |-> (out_r.rank < top_k_r))
    else $error("hit reported with rank not below top_k");

  // no beat is taken before the clearing pass has finished
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> !(out_valid_r && $rose(out_valid_r)))
    else $error("result produced during clearing pass");

endmodule

`default_nettype wire

>>> verif/markov_topk_symbol_predictor_unit_tb.sv
// markov_topk_symbol_predictor_unit_tb: self-checking bench for the markov top-k predictor
// depends on mtp_pkg and markov_topk_symbol_predictor_unit; holds its own count table to
// predict each result beat that a directed row does not give, and compares every beat field by field
module markov_topk_symbol_predictor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYM_W    = mtp_pkg::SYM_W;
  localparam int TOPK_W   = mtp_pkg::TOPK_W;
  localparam int REPORT_W = mtp_pkg::REPORT_W;

  localparam int ALPHA = 52;
  localparam logic [REPORT_W-1:0] COUNT_FULL = 16'hFFFF;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_BEATS = 150;
  localparam int LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  mtp_pkg::mtp_in_t in_data;
  logic out_valid;
  logic out_stall;
  mtp_pkg::mtp_out_t out_data;
  logic cfg_we;
  logic [TOPK_W-1:0] cfg_wdata;

  markov_topk_symbol_predictor_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the block state
  logic [REPORT_W-1:0] succ_count [ALPHA][ALPHA];
  logic [SYM_W-1:0] last_symbol;
  bit last_known;
  logic [TOPK_W-1:0] topk_shadow;

  mtp_pkg::mtp_out_t awaited_results [$];
  int mismatch_total = 0;

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  bit hold_request = 1'b0;

  typedef struct {
    mtp_pkg::mtp_in_t  beat;
    bit                typed;     // outcome below is checked as written
    mtp_pkg::mtp_out_t outcome;
  } beat_row_t;

  beat_row_t directed_rows [$];

  function automatic beat_row_t row(logic cmd, int sym, int nxt, bit typed,
                                    bit h, int rk, int cnt);
    beat_row_t r;
    r.beat.command = cmd;
    r.beat.symbol = sym[SYM_W-1:0];
    r.beat.next_symbol = nxt[SYM_W-1:0];
    r.typed = typed;
    r.outcome.hit = h;
    r.outcome.rank = rk[SYM_W-1:0];
    r.outcome.next_count = cnt[REPORT_W-1:0];
    return r;
  endfunction

  // works out the result of one beat and applies its effect on the shadow state
  function automatic mtp_pkg::mtp_out_t score_beat(mtp_pkg::mtp_in_t b);
    mtp_pkg::mtp_out_t r;
    logic [REPORT_W-1:0] target;
    int ahead;
    int j;
    r = '0;
    if (b.command == mtp_pkg::CMD_TRAIN) begin
      if (b.symbol < ALPHA) begin
        if (last_known) begin
          if (succ_count[last_symbol][b.symbol] != COUNT_FULL)
            succ_count[last_symbol][b.symbol] += 1'b1;
          r.next_count = succ_count[last_symbol][b.symbol];
        end
        last_symbol = b.symbol;
        last_known = 1'b1;
      end
    end else if (b.symbol >= ALPHA || b.next_symbol >= ALPHA) begin
      r.rank = SYM_W'(ALPHA - 1);
    end else begin
      target = succ_count[b.symbol][b.next_symbol];
      ahead = 0;
      for (j = 0; j < ALPHA; j++) begin
        if (succ_count[b.symbol][j] > target ||
            (succ_count[b.symbol][j] == target && j > b.next_symbol))
          ahead++;
      end
      r.hit = (ahead < topk_shadow);
      r.rank = ahead[SYM_W-1:0];
      r.next_count = target;
    end
    return r;
  endfunction

  // mostly symbols from a narrow hot window so rows build real counts
  function automatic logic [SYM_W-1:0] pick_symbol(int base);
    int roll;
    roll = $urandom_range(99);
    if (roll < 75)
      return SYM_W'(base + $urandom_range(7));
    else if (roll < 95)
      return SYM_W'($urandom_range(ALPHA - 1));
    else
      return SYM_W'($urandom_range(63, ALPHA));
  endfunction

  function automatic mtp_pkg::mtp_in_t random_beat(int base);
    mtp_pkg::mtp_in_t b;
    b.command = ($urandom_range(99) < 55) ? mtp_pkg::CMD_TRAIN : mtp_pkg::CMD_QUERY;
    b.symbol = pick_symbol(base);
    b.next_symbol = pick_symbol(base);
    return b;
  endfunction

  // called right after a rising edge; returns at the edge that takes the beat
  task automatic offer_beat(input mtp_pkg::mtp_in_t beat, input bit typed,
                            input mtp_pkg::mtp_out_t typed_out);
    bit taken;
    mtp_pkg::mtp_out_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) begin
        predicted = score_beat(beat);
        awaited_results.push_back(typed ? typed_out : predicted);
      end
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_topk(input logic [TOPK_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    topk_shadow = value;
  endtask

  task automatic flag_field(input string name, input int want, input int got);
    mismatch_total++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
  endtask

  // result side: decides its stall mid-cycle, drives it at the edge
  initial begin : result_sink
    int hold_left;
    bit stall_next;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else begin
        stall_next = ($urandom_range(99) < recv_gap_pct);
      end
      @(posedge clk);
      out_stall <= stall_next;
    end
  end

  // outputs are stable mid-cycle, so a beat seen here is taken at the next edge
  always @(negedge clk) begin : result_check
    mtp_pkg::mtp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        mismatch_total++;
        $display("%0t: result beat with none expected, expected nothing, got %h",
                 $realtime, out_data);
      end else begin
        want = awaited_results.pop_front();
        if (out_data.hit !== want.hit)
          flag_field("hit", want.hit, out_data.hit);
        if (out_data.rank !== want.rank)
          flag_field("rank", want.rank, out_data.rank);
        if (out_data.next_count !== want.next_count)
          flag_field("next_count", want.next_count, out_data.next_count);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int base;
    int a;
    int b;
    logic [TOPK_W-1:0] topk_plan [RAND_PHASES];

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    for (a = 0; a < ALPHA; a++)
      for (b = 0; b < ALPHA; b++)
        succ_count[a][b] = '0;
    last_symbol = '0;
    last_known = 1'b0;
    topk_shadow = mtp_pkg::TOPK_RESET;

    // cleared table, top_k at its reset value of 4
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 0, 51, 1, 1, 0, 0));  // all ties
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 0, 0, 1, 0, 51, 0));  // lowest ranks last
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 5, 48, 1, 1, 3, 0));  // last inside top_k
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 5, 47, 1, 0, 4, 0));  // first outside
    directed_rows.push_back(row(mtp_pkg::CMD_TRAIN, 63, 0, 1, 0, 0, 0));  // out of range
    directed_rows.push_back(row(mtp_pkg::CMD_TRAIN, 10, 63, 1, 0, 0, 0)); // no predecessor
    directed_rows.push_back(row(mtp_pkg::CMD_TRAIN, 20, 0, 1, 0, 0, 1));
    directed_rows.push_back(row(mtp_pkg::CMD_TRAIN, 20, 0, 1, 0, 0, 1));  // self transition
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 10, 20, 1, 1, 0, 1));
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 10, 51, 1, 1, 1, 0));
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 52, 0, 1, 0, 51, 0)); // current out
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 3, 63, 1, 0, 51, 0)); // next out
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 63, 63, 1, 0, 51, 0));
    directed_rows.push_back(row(mtp_pkg::CMD_TRAIN, 52, 63, 1, 0, 0, 0)); // keeps predecessor
    directed_rows.push_back(row(mtp_pkg::CMD_TRAIN, 0, 0, 1, 0, 0, 1));
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 20, 0, 1, 1, 1, 1));  // tie lost
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 20, 20, 1, 1, 0, 1)); // tie won
    directed_rows.push_back(row(mtp_pkg::CMD_TRAIN, 51, 0, 1, 0, 0, 1));
    directed_rows.push_back(row(mtp_pkg::CMD_TRAIN, 51, 0, 1, 0, 0, 1));
    directed_rows.push_back(row(mtp_pkg::CMD_TRAIN, 0, 0, 1, 0, 0, 1));
    directed_rows.push_back(row(mtp_pkg::CMD_TRAIN, 51, 0, 1, 0, 0, 2));
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 0, 51, 1, 1, 0, 2));
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 51, 0, 1, 1, 1, 1));
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 51, 25, 0, 0, 0, 0));
    directed_rows.push_back(row(mtp_pkg::CMD_QUERY, 33, 7, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, with the clearing pass still holding off the first beat
    send_gap_pct = 6;
    recv_gap_pct = 60;
    foreach (directed_rows[i])
      offer_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].outcome);
    drain_results();

    // random phases over several top_k settings and idle patterns
    topk_plan[0] = 6'd1;
    topk_plan[1] = 6'd63;
    topk_plan[2] = 6'd0;
    topk_plan[3] = 6'd52;
    topk_plan[4] = TOPK_W'($urandom_range(51, 2));
    topk_plan[5] = TOPK_W'($urandom_range(63));
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      set_topk(topk_plan[phase]);
      case (phase / 2)
        0: begin
          send_gap_pct = 6;
          recv_gap_pct = 60;
        end
        1: begin
          send_gap_pct = 60;
          recv_gap_pct = 6;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      // long result hold while beats keep coming, backs up into in_stall
      if (phase == 4)
        hold_request = 1'b1;
      base = $urandom_range(ALPHA - 8);
      for (n = 0; n < PHASE_BEATS; n++)
        offer_beat(random_beat(base), 1'b0, '0);
      drain_results();
    end

    repeat (ALPHA + 16) @(posedge clk);
    if (mismatch_total == 0 && awaited_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> markov_topk_symbol_predictor_unit.f
rtl/mtp_pkg.sv
rtl/mtp_count_ram.sv
rtl/mtp_rank_unit.sv
rtl/markov_topk_symbol_predictor_unit.sv
verif/markov_topk_symbol_predictor_unit_tb.sv
